/* design/qrm_pkg.sv */
// package: widths, constants and stage types of the quaternion to matrix pipeline
package qrm_pkg;

    localparam int FRAC_BITS = 14;
    localparam int IN_W      = 16;
    localparam int OUT_W     = 16;
    localparam int PROD_W    = 2 * IN_W;
    localparam int NORM_W    = PROD_W + 1;
    localparam int NUM_W     = PROD_W + 2;
    localparam int REM_W     = NORM_W + 1;
    localparam int QUO_W     = FRAC_BITS + 2;
    localparam int LANES     = 9;
    localparam int STAGES    = QUO_W + 3;

    localparam logic [31:0]      ONE     = 32'd1 << FRAC_BITS;
    localparam logic [OUT_W-1:0] ONE_OUT = ONE[OUT_W-1:0];

    // registered products of the quaternion components
    typedef struct packed {
        logic signed [PROD_W-1:0] xx;
        logic signed [PROD_W-1:0] yy;
        logic signed [PROD_W-1:0] zz;
        logic signed [PROD_W-1:0] ww;
        logic signed [PROD_W-1:0] xy;
        logic signed [PROD_W-1:0] wz;
        logic signed [PROD_W-1:0] zx;
        logic signed [PROD_W-1:0] wy;
        logic signed [PROD_W-1:0] yz;
        logic signed [PROD_W-1:0] wx;
    } t_prod;

    // state of the nine divider lanes between stages
    typedef struct packed {
        logic [NORM_W-1:0]                norm;
        logic                             zero;
        logic [LANES-1:0]                 neg;
        logic [LANES-1:0][REM_W-1:0]      rem;
        logic [LANES-1:0][QUO_W-1:0]      quo;
    } t_lanes;

endpackage

/* design/qrm_quat_if.sv */
// input channel: one quaternion per transfer
interface qrm_quat_if import qrm_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [IN_W-1:0]  quat_x;
    logic signed [IN_W-1:0]  quat_y;
    logic signed [IN_W-1:0]  quat_z;
    logic signed [IN_W-1:0]  quat_w;

    modport source (output valid, quat_x, quat_y, quat_z, quat_w, input ready);
    modport sink   (input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

/* design/qrm_mat_if.sv */
// output channel: one rotation matrix per transfer
interface qrm_mat_if import qrm_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] right_x;
    logic signed [OUT_W-1:0] right_y;
    logic signed [OUT_W-1:0] right_z;
    logic signed [OUT_W-1:0] up_x;
    logic signed [OUT_W-1:0] up_y;
    logic signed [OUT_W-1:0] up_z;
    logic signed [OUT_W-1:0] at_x;
    logic signed [OUT_W-1:0] at_y;
    logic signed [OUT_W-1:0] at_z;
    logic                    zero_quaternion;

    modport source (output valid, right_x, right_y, right_z, up_x, up_y, up_z,
                    at_x, at_y, at_z, zero_quaternion, input ready);
    modport sink   (input valid, right_x, right_y, right_z, up_x, up_y, up_z,
                    at_x, at_y, at_z, zero_quaternion, output ready);
endinterface

/* design/quaternion_to_rotation_matrix_unit.sv */
// top level: quaternion to 3x3 rotation matrix pipeline
//
// Input channel i_quat carries one quaternion (x, y, z, w, signed Q2.14) per
// transfer; output channel o_mat carries the nine matrix entries (signed
// Q2.14, rounded to nearest, saturated to +/-1.0) and a zero_quaternion flag,
// which is set with an identity matrix when all components are zero.
// The pipeline holds one product stage, one norm/numerator stage,
// FRAC_BITS + 2 restoring division steps shared by nine parallel lanes,
// and one rounding/output register.
// Throughput is one transfer per cycle while o_mat.ready is high; each
// division step is one compare and subtract per lane.
// Every stage has its own valid bit and advances when it is empty or the
// stage after it advances, so bubbles close up and a stalled receiver only
// holds the stages that are full; i_quat.ready drops once the whole pipe is
// full and o_mat.ready is low. Reset (synchronous, active low) clears every
// valid bit; data in flight is dropped.
module quaternion_to_rotation_matrix_unit import qrm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    qrm_quat_if.sink  i_quat,
    qrm_mat_if.source o_mat
);
    logic [STAGES-1:0]   vld, en;
    t_lanes              lanes [QUO_W+1];
    logic [LANES-1:0][OUT_W-1:0] entry;
    logic                zero;

    // stage enables: advance when empty or when the next stage advances
    always_comb begin
        en[STAGES-1] = !vld[STAGES-1] || o_mat.ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            en[k] = !vld[k] || en[k+1];
        end
    end

    assign i_quat.ready = en[0];

    qrm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en_a  (en[0]),
        .i_en_b  (en[1]),
        .i_vld   (i_quat.valid),
        .i_x     (i_quat.quat_x),
        .i_y     (i_quat.quat_y),
        .i_z     (i_quat.quat_z),
        .i_w     (i_quat.quat_w),
        .o_vld_a (vld[0]),
        .o_vld_b (vld[1]),
        .o_lanes (lanes[0])
    );

    // division step chain
    for (genvar g = 0; g < QUO_W; g++) begin : g_div
        qrm_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en[g+2]),
            .i_vld   (vld[g+1]),
            .i_lanes (lanes[g]),
            .o_vld   (vld[g+2]),
            .o_lanes (lanes[g+1])
        );
    end

    qrm_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en[STAGES-1]),
        .i_vld   (vld[STAGES-2]),
        .i_lanes (lanes[QUO_W]),
        .o_vld   (vld[STAGES-1]),
        .o_entry (entry),
        .o_zero  (zero)
    );

    // output transfer
    assign o_mat.valid           = vld[STAGES-1];
    assign o_mat.right_x         = entry[0];
    assign o_mat.right_y         = entry[1];
    assign o_mat.right_z         = entry[2];
    assign o_mat.up_x            = entry[3];
    assign o_mat.up_y            = entry[4];
    assign o_mat.up_z            = entry[5];
    assign o_mat.at_x            = entry[6];
    assign o_mat.at_y            = entry[7];
    assign o_mat.at_z            = entry[8];
    assign o_mat.zero_quaternion = zero;
endmodule

/* design/qrm_front.sv */
// front end: component products, then norm and the nine signed numerators
module qrm_front import qrm_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en_a,
    input  logic                   i_en_b,
    input  logic                   i_vld,
    input  logic signed [IN_W-1:0] i_x,
    input  logic signed [IN_W-1:0] i_y,
    input  logic signed [IN_W-1:0] i_z,
    input  logic signed [IN_W-1:0] i_w,
    output logic                   o_vld_a,
    output logic                   o_vld_b,
    output t_lanes                 o_lanes
);
    logic                           r_vld_a, r_vld_b;
    t_prod                          r_prod, n_prod;
    t_lanes                         r_lanes, n_lanes;
    logic [LANES-1:0][NUM_W-1:0]    num;

    // products, one multiplier each
    always_comb begin
        n_prod.xx = i_x * i_x;
        n_prod.yy = i_y * i_y;
        n_prod.zz = i_z * i_z;
        n_prod.ww = i_w * i_w;
        n_prod.xy = i_x * i_y;
        n_prod.wz = i_w * i_z;
        n_prod.zx = i_z * i_x;
        n_prod.wy = i_w * i_y;
        n_prod.yz = i_y * i_z;
        n_prod.wx = i_w * i_x;
    end

    // numerators of the nine entries, times the norm
    always_comb begin
        num[0] = NUM_W'(r_prod.xx) + NUM_W'(r_prod.ww) - NUM_W'(r_prod.yy) - NUM_W'(r_prod.zz);
        num[1] = (NUM_W'(r_prod.xy) + NUM_W'(r_prod.wz)) <<< 1;
        num[2] = (NUM_W'(r_prod.zx) - NUM_W'(r_prod.wy)) <<< 1;
        num[3] = (NUM_W'(r_prod.xy) - NUM_W'(r_prod.wz)) <<< 1;
        num[4] = NUM_W'(r_prod.yy) + NUM_W'(r_prod.ww) - NUM_W'(r_prod.zz) - NUM_W'(r_prod.xx);
        num[5] = (NUM_W'(r_prod.yz) + NUM_W'(r_prod.wx)) <<< 1;
        num[6] = (NUM_W'(r_prod.zx) + NUM_W'(r_prod.wy)) <<< 1;
        num[7] = (NUM_W'(r_prod.yz) - NUM_W'(r_prod.wx)) <<< 1;
        num[8] = NUM_W'(r_prod.zz) + NUM_W'(r_prod.ww) - NUM_W'(r_prod.xx) - NUM_W'(r_prod.yy);
    end

    // norm, signs and magnitudes as the first partial remainders
    always_comb begin
        n_lanes.norm = NORM_W'($unsigned(r_prod.xx)) + NORM_W'($unsigned(r_prod.yy))
                     + NORM_W'($unsigned(r_prod.zz)) + NORM_W'($unsigned(r_prod.ww));
        n_lanes.zero = (n_lanes.norm == '0);
        for (int k = 0; k < LANES; k++) begin
            n_lanes.neg[k] = num[k][NUM_W-1];
            n_lanes.rem[k] = num[k][NUM_W-1] ? REM_W'(NUM_W'(0) - num[k]) : REM_W'(num[k]);
            n_lanes.quo[k] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
        end else begin
            if (i_en_a) r_vld_a <= i_vld;
            if (i_en_b) r_vld_b <= r_vld_a;
        end
        if (i_en_a) r_prod  <= n_prod;
        if (i_en_b) r_lanes <= n_lanes;
    end

    assign o_vld_a = r_vld_a;
    assign o_vld_b = r_vld_b;
    assign o_lanes = r_lanes;
endmodule

/* design/qrm_div_step.sv */
// one restoring division step for all nine lanes, registered
module qrm_div_step import qrm_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_en,
    input  logic   i_vld,
    input  t_lanes i_lanes,
    output logic   o_vld,
    output t_lanes o_lanes
);
    logic   r_vld;
    t_lanes r_lanes, n_lanes;
    logic [LANES-1:0]            ge;
    logic [LANES-1:0][REM_W-1:0] diff;

    // compare against the norm, subtract, shift in the quotient bit
    always_comb begin
        n_lanes.norm = i_lanes.norm;
        n_lanes.zero = i_lanes.zero;
        n_lanes.neg  = i_lanes.neg;
        for (int k = 0; k < LANES; k++) begin
            ge[k]   = i_lanes.rem[k] >= REM_W'(i_lanes.norm);
            diff[k] = ge[k] ? (i_lanes.rem[k] - REM_W'(i_lanes.norm)) : i_lanes.rem[k];
            n_lanes.rem[k] = {diff[k][REM_W-2:0], 1'b0};
            n_lanes.quo[k] = {i_lanes.quo[k][QUO_W-2:0], ge[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
        if (i_en) r_lanes <= n_lanes;
    end

    assign o_vld   = r_vld;
    assign o_lanes = r_lanes;
endmodule

/* design/qrm_round.sv */
// output stage: round, saturate, apply sign, identity for a zero quaternion
module qrm_round import qrm_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_en,
    input  logic   i_vld,
    input  t_lanes i_lanes,
    output logic   o_vld,
    output logic [LANES-1:0][OUT_W-1:0] o_entry,
    output logic   o_zero
);
    logic                        r_vld;
    logic [LANES-1:0][OUT_W-1:0] r_entry, n_entry;
    logic                        r_zero;
    logic [QUO_W:0]              rq;
    logic [31:0]                 qe, sv;

    // the extra quotient bit rounds half away from zero on the magnitude
    always_comb begin
        rq = '0;
        qe = '0;
        sv = '0;
        for (int k = 0; k < LANES; k++) begin
            rq = ((QUO_W+1)'(i_lanes.quo[k]) + (QUO_W+1)'(1)) >> 1;
            qe = 32'(rq);
            if (qe > ONE) qe = ONE;
            sv = i_lanes.neg[k] ? (32'd0 - qe) : qe;
            if (i_lanes.zero) begin
                n_entry[k] = (k == 0 || k == 4 || k == 8) ? ONE_OUT : '0;
            end else begin
                n_entry[k] = sv[OUT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
        if (i_en) begin
            r_entry <= n_entry;
            r_zero  <= i_lanes.zero;
        end
    end

    assign o_vld   = r_vld;
    assign o_entry = r_entry;
    assign o_zero  = r_zero;
endmodule
